// ===== src/rrw_pkg.sv =====
// Shared constants, codes and types of the receive reorder window.
package rrw_pkg;

  localparam int WINDOW_SLOTS = 64;
  localparam int IDX_W = $clog2(WINDOW_SLOTS);
  localparam int RESULT_CAP = 64;
  localparam int LIMIT_W = 7;
  localparam int SACK_W = 32;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SEQUENCE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_CAP = 8'd1;

  localparam logic [1:0] MODE_UNREL_UNORD = 2'd0;
  localparam logic [1:0] MODE_UNREL_ORD = 2'd1;
  localparam logic [1:0] MODE_REL_UNORD = 2'd2;
  localparam logic [1:0] MODE_REL_ORD = 2'd3;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_DROPPED = 2'd1;
  localparam logic [1:0] STATUS_REFUSED = 2'd2;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_ORDERED,
    KIND_RELIABLE
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] seq;
    logic [1:0]  mode;
    logic [15:0] len;
    logic [15:0] handle;
  } item_t;

endpackage

// ===== src/receive_reorder_window_top.sv =====
// Top level of the receive reorder window with cumulative and selective ack.
// A packet header request is registered by the front stage and passes through a two-entry
// queue; the back stage then handles one header at a time. A header that is not stored goes
// from the idle state to the emit state, which loads the result register. A reliable header
// that is stored adds a drain walk in the count state that clears the held run, then its own
// unordered delivery from the emit state; each reordered delivery goes from the emit state,
// where the payload memory is read, to the read-data state that loads the result register,
// and each already-delivered slot is skipped in the emit state. A stalled result holds the
// back stage, while the front and the queue keep taking up to three more requests. The held
// flags are flip-flops cleared at reset and on a write of initial_sequence, so no clearing
// pass is needed. The configuration port is always ready.
module receive_reorder_window_top
  import rrw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          packet_seq,
  input  logic [1:0]           pkt_mode,
  input  logic [15:0]          packet_len,
  input  logic [15:0]          payload_handle,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 deliver_valid,
  output logic [31:0]          out_seq,
  output logic [1:0]           out_mode,
  output logic [15:0]          out_len,
  output logic [15:0]          out_handle,
  output logic                 last_of_run,
  output logic [31:0]          ack_num,
  output logic [31:0]          ack_bitmap,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic  push;
  item_t push_item;
  logic  queue_full;
  logic  q_not_empty;
  logic  q_pop;
  item_t q_item;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  rrw_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .packet_seq(packet_seq), .pkt_mode(pkt_mode), .packet_len(packet_len),
    .payload_handle(payload_handle), .push(push), .push_item(push_item),
    .queue_full(queue_full)
  );

  rrw_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_item(push_item), .full(queue_full),
    .not_empty(q_not_empty), .pop(q_pop), .pop_item(q_item)
  );

  rrw_back u_back (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .q_not_empty(q_not_empty), .q_item(q_item), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .deliver_valid(deliver_valid), .out_seq(out_seq), .out_mode(out_mode),
    .out_len(out_len), .out_handle(out_handle), .last_of_run(last_of_run),
    .ack_num(ack_num), .ack_bitmap(ack_bitmap)
  );

endmodule

// ===== src/rrw_front.sv =====
// Front stage: takes input requests into a register and classifies them by mode.
module rrw_front
  import rrw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] packet_seq,
  input  logic [1:0]  pkt_mode,
  input  logic [15:0] packet_len,
  input  logic [15:0] payload_handle,
  output logic        push,
  output item_t       push_item,
  input  logic        queue_full
);

  logic  held;
  item_t item;
  kind_t kind_next;

  always_comb begin
    unique case (pkt_mode)
      MODE_UNREL_UNORD: kind_next = KIND_PASS;
      MODE_UNREL_ORD:   kind_next = KIND_ORDERED;
      default:          kind_next = KIND_RELIABLE;
    endcase
  end

  assign push = held && !queue_full;
  assign in_stall = held && queue_full;
  assign push_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (in_valid && !in_stall) begin
      item.kind <= kind_next;
      item.seq <= packet_seq;
      item.mode <= pkt_mode;
      item.len <= packet_len;
      item.handle <= payload_handle;
    end
  end

endmodule

// ===== src/rrw_queue.sv =====
// Two-entry queue of classified requests between the front and back stages.
module rrw_queue
  import rrw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  not_empty,
  input  logic  pop,
  output item_t pop_item
);

  item_t      entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_item = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
    if (push) entry[wr_ptr] <= push_item;
  end

endmodule

// ===== src/rrw_back.sv =====
// Back stage: window state, drain sequencer, configuration registers and result register.
module rrw_back
  import rrw_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 q_not_empty,
  input  item_t                q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           status,
  output logic                 deliver_valid,
  output logic [31:0]          out_seq,
  output logic [1:0]           out_mode,
  output logic [15:0]          out_len,
  output logic [15:0]          out_handle,
  output logic                 last_of_run,
  output logic [31:0]          ack_num,
  output logic [31:0]          ack_bitmap
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_EMIT,
    S_RDATA
  } state_t;

  state_t                  state;
  logic [LIMIT_W-1:0]      ready_cap;
  logic [31:0]             expected;
  logic [31:0]             hi_seq;
  logic                    has_hi;
  logic [WINDOW_SLOTS-1:0] held;
  logic [WINDOW_SLOTS-1:0] is_m2;
  logic [31:0]             mem [WINDOW_SLOTS];
  logic [31:0]             rdata;

  item_t              cur;
  logic [1:0]         cur_status;
  logic               pend;
  logic               none;
  logic [LIMIT_W-1:0] n;
  logic [LIMIT_W-1:0] lim;
  logic [31:0]        p;
  logic [31:0]        q;

  logic               out_free;
  logic               load_out;
  logic [31:0]        d_rel;
  logic [31:0]        d_ord;
  logic [IDX_W-1:0]   new_idx;
  logic [IDX_W-1:0]   p_idx;
  logic [IDX_W-1:0]   q_idx;
  logic               mem_we;
  logic [SACK_W-1:0]  sack;
  logic [LIMIT_W-1:0] lim_next;

  assign out_free = !out_valid || !out_stall;
  assign load_out = out_free && (((state == S_EMIT) && (none || pend)) || (state == S_RDATA));
  assign q_pop = (state == S_IDLE) && q_not_empty;
  assign d_rel = q_item.seq - expected;
  assign d_ord = q_item.seq - hi_seq;
  assign new_idx = q_item.seq[IDX_W-1:0];
  assign p_idx = p[IDX_W-1:0];
  assign q_idx = q[IDX_W-1:0];

  always_comb begin
    if (ready_cap == '0) lim_next = LIMIT_W'(1);
    else if (ready_cap > LIMIT_W'(RESULT_CAP)) lim_next = LIMIT_W'(RESULT_CAP);
    else lim_next = ready_cap;
  end

  // A slot counts as held for the sequence at the same offset from expected.
  always_comb begin
    for (int i = 0; i < SACK_W; i++) begin
      sack[i] = (i < WINDOW_SLOTS) && held[expected[IDX_W-1:0] + IDX_W'(i)];
    end
  end

  assign mem_we = q_pop && (q_item.kind == KIND_RELIABLE) && !d_rel[31]
                  && (d_rel < 32'(WINDOW_SLOTS)) && !held[new_idx];

  always_ff @(posedge clk) begin
    if (mem_we) mem[new_idx] <= {q_item.len, q_item.handle};
    rdata <= mem[q_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ready_cap <= LIMIT_W'(RESULT_CAP);
      expected <= '0;
      hi_seq <= '0;
      has_hi <= 1'b0;
      held <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_INITIAL_SEQUENCE) begin
          expected <= cfg_data;
          hi_seq <= '0;
          has_hi <= 1'b0;
          held <= '0;
        end else if (cfg_index == CFG_READY_CAP) begin
          ready_cap <= cfg_data[LIMIT_W-1:0];
        end
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            cur <= q_item;
            lim <= lim_next;
            p <= expected;
            q <= expected;
            unique case (q_item.kind)
              KIND_PASS: begin
                cur_status <= STATUS_ACCEPTED;
                pend <= 1'b1;
                none <= 1'b0;
                n <= LIMIT_W'(1);
                state <= S_EMIT;
              end
              KIND_ORDERED: begin
                state <= S_EMIT;
                if (!has_hi || (d_ord != '0 && !d_ord[31])) begin
                  hi_seq <= q_item.seq;
                  has_hi <= 1'b1;
                  cur_status <= STATUS_ACCEPTED;
                  pend <= 1'b1;
                  none <= 1'b0;
                  n <= LIMIT_W'(1);
                end else begin
                  cur_status <= STATUS_DROPPED;
                  pend <= 1'b0;
                  none <= 1'b1;
                  n <= '0;
                end
              end
              default: begin
                if (d_rel[31] || (d_rel < 32'(WINDOW_SLOTS) && held[new_idx])) begin
                  cur_status <= STATUS_DROPPED;
                  pend <= 1'b0;
                  none <= 1'b1;
                  n <= '0;
                  state <= S_EMIT;
                end else if (d_rel >= 32'(WINDOW_SLOTS)) begin
                  cur_status <= STATUS_REFUSED;
                  pend <= 1'b0;
                  none <= 1'b1;
                  n <= '0;
                  state <= S_EMIT;
                end else begin
                  held[new_idx] <= 1'b1;
                  is_m2[new_idx] <= (q_item.mode == MODE_REL_UNORD);
                  cur_status <= STATUS_ACCEPTED;
                  none <= 1'b0;
                  pend <= (q_item.mode == MODE_REL_UNORD);
                  n <= (q_item.mode == MODE_REL_UNORD) ? LIMIT_W'(1) : '0;
                  state <= S_COUNT;
                end
              end
            endcase
          end
        end
        S_COUNT: begin
          // Walk the held run one slot a cycle, clearing as it goes.
          if (held[p_idx] && (is_m2[p_idx] || n < lim)) begin
            held[p_idx] <= 1'b0;
            if (!is_m2[p_idx]) n <= n + LIMIT_W'(1);
            p <= p + 32'd1;
          end else begin
            expected <= p;
            none <= (n == '0);
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (none) begin
            if (out_free) begin
              status <= cur_status;
              deliver_valid <= 1'b0;
              out_seq <= '0;
              out_mode <= '0;
              out_len <= '0;
              out_handle <= '0;
              last_of_run <= 1'b1;
              ack_num <= expected - 32'd1;
              ack_bitmap <= sack;
              state <= S_IDLE;
            end
          end else if (pend) begin
            if (out_free) begin
              status <= cur_status;
              deliver_valid <= 1'b1;
              out_seq <= cur.seq;
              out_mode <= cur.mode;
              out_len <= cur.len;
              out_handle <= cur.handle;
              last_of_run <= (n == LIMIT_W'(1));
              ack_num <= expected - 32'd1;
              ack_bitmap <= sack;
              pend <= 1'b0;
              n <= n - LIMIT_W'(1);
              if (n == LIMIT_W'(1)) state <= S_IDLE;
            end
          end else if (is_m2[q_idx]) begin
            // Already delivered on arrival.
            q <= q + 32'd1;
          end else begin
            state <= S_RDATA;
          end
        end
        S_RDATA: begin
          if (out_free) begin
            status <= cur_status;
            deliver_valid <= 1'b1;
            out_seq <= q;
            out_mode <= MODE_REL_ORD;
            out_len <= rdata[31:16];
            out_handle <= rdata[15:0];
            last_of_run <= (n == LIMIT_W'(1));
            ack_num <= expected - 32'd1;
            ack_bitmap <= sack;
            n <= n - LIMIT_W'(1);
            q <= q + 32'd1;
            state <= (n == LIMIT_W'(1)) ? S_IDLE : S_EMIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
